// ===== sv/first_fit_pool_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion macros for the first-fit pool allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FFPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFPA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFPA_ASSERT(lbl, clk, rst, prop, msg)
`define FFPA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants for the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int ADDR_W       = $clog2(POOL_BYTES);
  localparam int LEN_W        = ADDR_W;
  localparam int POS_W        = ADDR_W + 2;
  localparam int ENT_W        = LEN_W + 2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd1;
  localparam logic [2:0] ST_NO_SPACE    = 3'd2;
  localparam logic [2:0] ST_BAD_PTR     = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] req_size;
    logic [12:0] free_offset;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] payload_offset;
  } rsp_item_t;

  typedef struct packed {
    logic             start;
    logic             free;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_SPLIT,
    S_F_CHK,
    S_C_START,
    S_C_S,
    S_C_N,
    S_C_WS,
    S_DONE
  } state_t;

endpackage

// ===== sv/first_fit_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// First-fit pool allocator with split on allocate and coalescing on free.
// ----------------------------------------------------------------------------
// Channel  Signals                    Dir  Payload
// req      req_valid/req_ready/req    in   func, req_size, free_offset
// rsp      rsp_valid/rsp_ready/rsp    out  status, payload_offset
//
// Allocate: S_A_CHK walks the chunks; S_A_SPLIT writes the rest when it splits.
// Free: S_F_CHK, S_C_START, the coalesce walk in S_C_S/S_C_N, and S_C_WS when a merge
// runs to the pool end; every chunk visit is one read of the chunk RAM.
// After reset a clearing pass over all POOL_BYTES (4096) RAM entries holds req_ready low.
// One item at a time; a waiting result stalls only the final hand-off.
// ----------------------------------------------------------------------------
`include "first_fit_pool_allocator_core_macros.svh"

module first_fit_pool_allocator_core
  import ffpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam logic [POS_W-1:0] HDR  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POOL = POS_W'(POOL_BYTES);
  localparam logic [LEN_W-1:0] INIT_LEN = LEN_W'(POOL_BYTES - HEADER_BYTES);

  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [15:0]       size, size_next;
  logic [ADDR_W-1:0] s, s_next;
  logic [ADDR_W-1:0] nadr, nadr_next;
  logic [LEN_W-1:0]  cur_len, cur_len_next;
  logic [2:0]        res_status, res_status_next;
  logic [12:0]       res_pay, res_pay_next;
  logic              rsp_valid_next;
  rsp_item_t         rsp_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;
  logic [ENT_W-1:0]  rd_bits;

  ffpa_ram #(.WIDTH(ENT_W), .DEPTH(POOL_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );
  assign rd = entry_t'(rd_bits);

  // shared datapath
  logic [ADDR_W-1:0] base;
  logic [POS_W-1:0]  cand;
  logic              cand_end;
  logic              fit, split, bad_size, off_bad, can_out, accept;
  logic [16:0]       off_sub;
  logic [16:0]       size_hdr;
  logic [LEN_W-1:0]  merged_len, rest_len;
  logic [ADDR_W-1:0] split_adr;
  logic [12:0]       pay_s;

  assign base       = (state == S_C_N) ? nadr : s;
  assign cand       = {2'b00, base} + HDR + {2'b00, rd.len};
  assign cand_end   = cand >= POOL;
  assign size_hdr   = {1'b0, size} + 17'(HEADER_BYTES);
  assign fit        = rd.free && ({5'd0, rd.len} >= {1'b0, size});
  assign split      = {5'd0, rd.len} > size_hdr;
  assign rest_len   = LEN_W'({5'd0, rd.len} - size_hdr);
  assign split_adr  = ADDR_W'({5'd0, s} + size_hdr);
  assign merged_len = LEN_W'(cur_len + LEN_W'(HEADER_BYTES) + rd.len);
  assign pay_s      = 13'({5'd0, s} + 17'(HEADER_BYTES));
  assign bad_size   = (req.req_size == 16'd0) || ({1'b0, req.req_size} > 17'(POOL_BYTES));
  assign off_sub    = {4'd0, req.free_offset} - 17'(HEADER_BYTES);
  assign off_bad    = (req.free_offset < 13'(HEADER_BYTES)) ||
                      (off_sub >= 17'(POOL_BYTES));
  assign can_out    = !rsp_valid || rsp_ready;
  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      rsp_valid <= rsp_valid_next;
    end
    size       <= size_next;
    s          <= s_next;
    nadr       <= nadr_next;
    cur_len    <= cur_len_next;
    res_status <= res_status_next;
    res_pay    <= res_pay_next;
    rsp        <= rsp_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_ALLOC) begin
            state_next = bad_size ? S_DONE : S_A_CHK;
          end else begin
            state_next = off_bad ? S_DONE : S_F_CHK;
          end
        end
      end
      S_A_CHK: begin
        if (fit) state_next = split ? S_A_SPLIT : S_DONE;
        else if (cand_end) state_next = S_DONE;
      end
      S_A_SPLIT: state_next = S_DONE;
      S_F_CHK: begin
        if (!rd.start || rd.free) state_next = S_DONE;
        else state_next = S_C_START;
      end
      S_C_START: state_next = S_C_S;
      S_C_S: begin
        if (cand_end) state_next = S_DONE;
        else if (rd.free) state_next = S_C_N;
      end
      S_C_N: begin
        if (rd.free) begin
          if (cand_end) state_next = S_C_WS;
        end else begin
          state_next = cand_end ? S_DONE : S_C_S;
        end
      end
      S_C_WS: state_next = S_DONE;
      S_DONE: begin
        if (can_out) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_addr_next   = clr_addr;
    size_next       = size;
    s_next          = s;
    nadr_next       = nadr;
    cur_len_next    = cur_len;
    res_status_next = res_status;
    res_pay_next    = res_pay;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    rsp_next        = rsp;
    ram_we          = 1'b0;
    ram_waddr       = s;
    ram_wdata       = '0;
    ram_raddr       = s;
    case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = (clr_addr == '0) ? entry_t'{1'b1, 1'b1, INIT_LEN} : '0;
        clr_addr_next = clr_addr + ADDR_W'(1);
      end
      S_IDLE: begin
        res_pay_next = '0;
        size_next    = req.req_size;
        if (accept) begin
          if (req.func == FUNC_ALLOC) begin
            s_next          = '0;
            ram_raddr       = '0;
            res_status_next = bad_size ? ST_BAD_SIZE : ST_OK;
          end else begin
            s_next          = off_sub[ADDR_W-1:0];
            ram_raddr       = off_sub[ADDR_W-1:0];
            res_status_next = off_bad ? ST_BAD_PTR : ST_OK;
          end
        end
      end
      S_A_CHK: begin
        if (fit) begin
          ram_we       = 1'b1;
          ram_waddr    = s;
          ram_wdata    = entry_t'{1'b1, 1'b0, split ? LEN_W'(size) : rd.len};
          cur_len_next = rest_len;
          nadr_next    = split_adr;
          res_pay_next = pay_s;
        end else if (cand_end) begin
          res_status_next = ST_NO_SPACE;
        end else begin
          s_next    = ADDR_W'(cand);
          ram_raddr = ADDR_W'(cand);
        end
      end
      S_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = nadr;
        ram_wdata = entry_t'{1'b1, 1'b1, cur_len};
      end
      S_F_CHK: begin
        if (!rd.start) begin
          res_status_next = ST_BAD_PTR;
        end else if (rd.free) begin
          res_status_next = ST_DOUBLE_FREE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = s;
          ram_wdata = entry_t'{1'b1, 1'b1, rd.len};
        end
      end
      S_C_START: begin
        s_next    = '0;
        ram_raddr = '0;
      end
      S_C_S: begin
        if (!cand_end) begin
          ram_raddr = ADDR_W'(cand);
          if (rd.free) begin
            cur_len_next = rd.len;
            nadr_next    = ADDR_W'(cand);
          end else begin
            s_next = ADDR_W'(cand);
          end
        end
      end
      S_C_N: begin
        if (rd.free) begin
          ram_we       = 1'b1;
          ram_waddr    = nadr;
          ram_wdata    = '0;
          cur_len_next = merged_len;
          nadr_next    = ADDR_W'(cand);
          ram_raddr    = ADDR_W'(cand);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = s;
          ram_wdata = entry_t'{1'b1, 1'b1, cur_len};
          s_next    = ADDR_W'(cand);
          ram_raddr = ADDR_W'(cand);
        end
      end
      S_C_WS: begin
        ram_we    = 1'b1;
        ram_waddr = s;
        ram_wdata = entry_t'{1'b1, 1'b1, cur_len};
      end
      S_DONE: begin
        if (can_out) begin
          rsp_valid_next          = 1'b1;
          rsp_next.status         = res_status;
          rsp_next.payload_offset = (res_status == ST_OK) ? res_pay : '0;
        end
      end
      default: begin
      end
    endcase
  end

  `FFPA_ASSERT(a_accept_leaves_idle, clk, rst, (req_valid && req_ready) |=> (state != S_IDLE), "accepted item did not start work")
  `FFPA_ASSERT(a_pay_only_ok, clk, rst, (rsp_valid && (rsp.payload_offset != '0)) |-> (rsp.status == ST_OK), "payload offset on error status")
  `FFPA_ASSERT(a_no_write_idle, clk, rst, (state == S_IDLE) |-> !ram_we, "RAM write while idle")
  `FFPA_ASSERT(a_clear_after_reset, clk, rst, $past(rst) |-> (state == S_CLEAR), "no clearing pass after reset")

endmodule

// ===== sv/ffpa_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
